@@ design/salsa20_keystream_block_macros.svh @@
`ifndef SALSA20_KEYSTREAM_BLOCK_MACROS_SVH
`define SALSA20_KEYSTREAM_BLOCK_MACROS_SVH

// Same-cycle implication, checked outside reset
`define S20KS_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("s20ks: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define S20KS_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("s20ks: next-cycle check failed");

`endif

@@ design/s20ks_pkg.sv @@
package s20ks_pkg;

    typedef logic [31:0] word_t;
    typedef logic [15:0][31:0] matrix_t;

    typedef struct packed {
        logic [63:0] key_part0;
        logic [63:0] key_part1;
        logic [63:0] key_part2;
        logic [63:0] key_part3;
        logic [63:0] nonce_value;
        logic        long_key_mode;
    } cfg_t;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_RUN,
        CORE_HOLD
    } core_state_t;

    localparam logic [2:0] REG_KEY0  = 3'd0;
    localparam logic [2:0] REG_KEY1  = 3'd1;
    localparam logic [2:0] REG_KEY2  = 3'd2;
    localparam logic [2:0] REG_KEY3  = 3'd3;
    localparam logic [2:0] REG_NONCE = 3'd4;
    localparam logic [2:0] REG_MODE  = 3'd5;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam word_t CONST_0     = 32'h61707865;
    localparam word_t SIGMA_1     = 32'h3320646e;
    localparam word_t SIGMA_2     = 32'h79622d32;
    localparam word_t TAU_1       = 32'h3120646e;
    localparam word_t TAU_2       = 32'h79622d36;
    localparam word_t CONST_3     = 32'h6b206574;

    function automatic word_t rotl(input word_t v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic matrix_t quarter(input matrix_t x, input int a, input int b,
                                        input int c, input int d);
        matrix_t y;
        word_t   t;
        y = x;
        t = y[a] + y[d];
        y[b] = y[b] ^ rotl(t, 7);
        t = y[b] + y[a];
        y[c] = y[c] ^ rotl(t, 9);
        t = y[c] + y[b];
        y[d] = y[d] ^ rotl(t, 13);
        t = y[d] + y[c];
        y[a] = y[a] ^ rotl(t, 18);
        return y;
    endfunction

    function automatic matrix_t column_round(input matrix_t x);
        matrix_t y;
        y = quarter(x, 0, 4, 8, 12);
        y = quarter(y, 5, 9, 13, 1);
        y = quarter(y, 10, 14, 2, 6);
        y = quarter(y, 15, 3, 7, 11);
        return y;
    endfunction

    function automatic matrix_t row_round(input matrix_t x);
        matrix_t y;
        y = quarter(x, 0, 1, 2, 3);
        y = quarter(y, 5, 6, 7, 4);
        y = quarter(y, 10, 11, 8, 9);
        y = quarter(y, 15, 12, 13, 14);
        return y;
    endfunction

    function automatic matrix_t build_matrix(input cfg_t cfg, input logic [63:0] ctr);
        matrix_t m;
        logic [63:0] hi0;
        logic [63:0] hi1;
        hi0 = cfg.long_key_mode ? cfg.key_part2 : cfg.key_part0;
        hi1 = cfg.long_key_mode ? cfg.key_part3 : cfg.key_part1;
        m[0]  = CONST_0;
        m[1]  = cfg.key_part0[31:0];
        m[2]  = cfg.key_part0[63:32];
        m[3]  = cfg.key_part1[31:0];
        m[4]  = cfg.key_part1[63:32];
        m[5]  = cfg.long_key_mode ? SIGMA_1 : TAU_1;
        m[6]  = cfg.nonce_value[31:0];
        m[7]  = cfg.nonce_value[63:32];
        m[8]  = ctr[31:0];
        m[9]  = ctr[63:32];
        m[10] = cfg.long_key_mode ? SIGMA_2 : TAU_2;
        m[11] = hi0[31:0];
        m[12] = hi0[63:32];
        m[13] = hi1[31:0];
        m[14] = hi1[63:32];
        m[15] = CONST_3;
        return m;
    endfunction

endpackage

@@ design/s20ks_front.sv @@
`include "salsa20_keystream_block_macros.svh"

module s20ks_front (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] block_counter,
    output logic        q_valid,
    output logic [63:0] q_counter,
    input  logic        q_pop
);

    logic [63:0]                      entry_reg [s20ks_pkg::Q_DEPTH];
    logic [s20ks_pkg::Q_PTR_W-1:0]    wr_ptr_reg;
    logic [s20ks_pkg::Q_PTR_W-1:0]    rd_ptr_reg;
    logic [s20ks_pkg::Q_CNT_W-1:0]    count_reg;
    logic [s20ks_pkg::Q_CNT_W-1:0]    count_next;
    logic                             push;
    logic                             pop;

    assign in_stall  = (count_reg == s20ks_pkg::Q_CNT_W'(s20ks_pkg::Q_DEPTH));
    assign push      = in_valid && !in_stall;
    assign q_valid   = (count_reg != '0);
    assign pop       = q_pop && q_valid;
    assign q_counter = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= block_counter;
        end
    end

    `S20KS_ASSERT_NEXT(a_q_fill, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1)
    `S20KS_ASSERT_NOW(a_q_bound, clk, rst_n, 1'b1, count_reg <= s20ks_pkg::Q_CNT_W'(s20ks_pkg::Q_DEPTH))

endmodule

@@ design/s20ks_core.sv @@
`include "salsa20_keystream_block_macros.svh"

module s20ks_core #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  s20ks_pkg::cfg_t     cfg,
    input  logic                q_valid,
    input  logic [63:0]         q_counter,
    output logic                q_pop,
    output logic                blk_valid,
    input  logic                blk_take,
    output s20ks_pkg::matrix_t  blk_data
);

    localparam int ROUNDS = 2 * DOUBLE_ROUNDS;
    localparam int RND_W  = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS - 1);

    s20ks_pkg::core_state_t state_reg;
    s20ks_pkg::core_state_t state_next;
    logic [RND_W-1:0]       rnd_reg;
    logic [63:0]            ctr_reg;
    s20ks_pkg::matrix_t     x_reg;
    s20ks_pkg::matrix_t     init_m;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= s20ks_pkg::CORE_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        blk_valid  = 1'b0;
        unique case (state_reg)
            s20ks_pkg::CORE_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = s20ks_pkg::CORE_RUN;
                end
            end
            s20ks_pkg::CORE_RUN:
            begin
                if (rnd_reg == RND_LAST)
                begin
                    state_next = s20ks_pkg::CORE_HOLD;
                end
            end
            s20ks_pkg::CORE_HOLD:
            begin
                blk_valid = 1'b1;
                if (blk_take)
                begin
                    // chain straight into the next transaction when one is queued
                    if (q_valid)
                    begin
                        q_pop      = 1'b1;
                        state_next = s20ks_pkg::CORE_RUN;
                    end
                    else
                    begin
                        state_next = s20ks_pkg::CORE_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = s20ks_pkg::CORE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_reg <= '0;
        end
        else if (q_pop)
        begin
            rnd_reg <= '0;
        end
        else if (state_reg == s20ks_pkg::CORE_RUN)
        begin
            rnd_reg <= rnd_reg + 1'b1;
        end
    end

    // Even rounds are column rounds, odd rounds row rounds
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            ctr_reg <= q_counter;
            x_reg   <= s20ks_pkg::build_matrix(cfg, q_counter);
        end
        else if (state_reg == s20ks_pkg::CORE_RUN)
        begin
            x_reg <= rnd_reg[0] ? s20ks_pkg::row_round(x_reg)
                                : s20ks_pkg::column_round(x_reg);
        end
    end

    // Rebuild the input matrix from the held counter; the user must keep config stable while busy (not enforced here)
    assign init_m = s20ks_pkg::build_matrix(cfg, ctr_reg);

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            blk_data[i] = x_reg[i] + init_m[i];
        end
    end

    `S20KS_ASSERT_NEXT(a_run_end, clk, rst_n, (state_reg == s20ks_pkg::CORE_RUN) && (rnd_reg == RND_LAST), state_reg == s20ks_pkg::CORE_HOLD)

endmodule

@@ design/s20ks_out.sv @@
`include "salsa20_keystream_block_macros.svh"

module s20ks_out (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               blk_valid,
    output logic               blk_take,
    input  s20ks_pkg::matrix_t blk_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         word_index,
    output logic [31:0]        keystream_word,
    output logic               last_word
);

    s20ks_pkg::matrix_t words_reg;
    logic [3:0]         idx_reg;
    logic               busy_reg;
    logic               fire;
    logic               is_last;

    assign is_last        = (idx_reg == 4'hF);
    assign fire           = busy_reg && !out_stall;
    assign blk_take       = blk_valid && (!busy_reg || (fire && is_last));
    assign out_valid      = busy_reg;
    assign keystream_word = words_reg[0];
    assign word_index     = idx_reg;
    assign last_word      = is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (blk_take)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (fire)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (is_last)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Shift the block down one word per transaction
    always_ff @(posedge clk)
    begin
        if (blk_take)
        begin
            words_reg <= blk_data;
        end
        else if (fire)
        begin
            for (int i = 0; i < 15; i++)
            begin
                words_reg[i] <= words_reg[i + 1];
            end
        end
    end

    `S20KS_ASSERT_NEXT(a_load, clk, rst_n, blk_take, busy_reg && (idx_reg == 4'h0))
    `S20KS_ASSERT_NEXT(a_step, clk, rst_n, fire && !is_last, busy_reg && (idx_reg == $past(idx_reg) + 1'b1))

endmodule

@@ design/salsa20_keystream_block.sv @@
// Salsa20 keystream block: one 64-bit counter in, sixteen 32-bit words out.
// The counter is queued in the front stage and popped by the round core; the finished block
// is held until the output stage takes it. Throughput: one round per cycle, and sixteen words
// at one per cycle while out_stall is low; the core can start the next block while words stream.
// Reset: key parts and nonce clear to zero, long_key_mode sets to one, queue and
// output stage empty.
module salsa20_keystream_block #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] block_counter,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  word_index,
    output logic [31:0] keystream_word,
    output logic        last_word
);

    s20ks_pkg::cfg_t    cfg_reg;
    logic               q_valid;
    logic [63:0]        q_counter;
    logic               q_pop;
    logic               blk_valid;
    logic               blk_take;
    s20ks_pkg::matrix_t blk_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_part0     <= '0;
            cfg_reg.key_part1     <= '0;
            cfg_reg.key_part2     <= '0;
            cfg_reg.key_part3     <= '0;
            cfg_reg.nonce_value   <= '0;
            cfg_reg.long_key_mode <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                s20ks_pkg::REG_KEY0:  cfg_reg.key_part0     <= cfg_data;
                s20ks_pkg::REG_KEY1:  cfg_reg.key_part1     <= cfg_data;
                s20ks_pkg::REG_KEY2:  cfg_reg.key_part2     <= cfg_data;
                s20ks_pkg::REG_KEY3:  cfg_reg.key_part3     <= cfg_data;
                s20ks_pkg::REG_NONCE: cfg_reg.nonce_value   <= cfg_data;
                s20ks_pkg::REG_MODE:  cfg_reg.long_key_mode <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    s20ks_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .block_counter (block_counter),
        .q_valid       (q_valid),
        .q_counter     (q_counter),
        .q_pop         (q_pop)
    );

    s20ks_core #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_counter (q_counter),
        .q_pop     (q_pop),
        .blk_valid (blk_valid),
        .blk_take  (blk_take),
        .blk_data  (blk_data)
    );

    s20ks_out u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .blk_valid      (blk_valid),
        .blk_take       (blk_take),
        .blk_data       (blk_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .word_index     (word_index),
        .keystream_word (keystream_word),
        .last_word      (last_word)
    );

endmodule
